// ----- hw/rtl/dsaled_pkg.sv -----
// Shared types, constants and microcode program of the dual-sensor averaging block.
// No dependencies; used by dsaled_div and dual_sensor_average_led_drive_top.
package dsaled_pkg;

  localparam int SampleW  = 32;
  localparam int SumW     = 32;
  localparam int DataW    = 16;
  localparam int CountW   = 5;
  localparam int TickW    = 8;
  localparam int PcW      = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int GainW    = 12;
  localparam int ProdW    = DataW + GainW;
  localparam int ScaleShift = 10;
  localparam int ScaledW  = ProdW - ScaleShift;
  localparam int NumColors = 3;
  localparam int NumLanes  = 2;
  localparam int DivSteps  = DataW;
  localparam int DivCntW   = $clog2(DivSteps + 1);

  localparam int MaxCount = 24;

  localparam logic [DataW-1:0]   FullScale  = 16'hFFFF;
  localparam logic [GainW-1:0]   TempGain   = 12'd2581;
  localparam logic [ScaledW-1:0] TempOffset = 18'd35288;
  localparam logic [TickW-1:0]   TickMax    = 8'd255;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgChannelMode   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgReadoutSelect = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSampleCount   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgColorEnable   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLightThresh   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTempThresh    = 3'd5;

  // Reset values of the registers
  localparam logic [1:0]       RstChannelMode   = 2'd1;
  localparam logic             RstReadoutSelect = 1'b1;
  localparam logic [CountW-1:0] RstSampleCount  = 5'd0;
  localparam logic [2:0]       RstColorEnable   = 3'd0;
  localparam logic [DataW-1:0] RstLightThresh   = 16'd13351;
  localparam logic [DataW-1:0] RstTempThresh    = 16'd15000;

  localparam logic [1:0] ModeOff = 2'd0;
  localparam logic       ReadoutLight = 1'b0;

  // Microcode step addresses
  localparam logic [PcW-1:0] StepWait  = 3'd0;
  localparam logic [PcW-1:0] StepCheck = 3'd1;
  localparam logic [PcW-1:0] StepDiv   = 3'd2;
  localparam logic [PcW-1:0] StepStore = 3'd3;
  localparam logic [PcW-1:0] StepScale = 3'd4;
  localparam logic [PcW-1:0] StepLed   = 3'd5;
  localparam logic [PcW-1:0] StepEmit  = 3'd6;
  localparam logic [PcW-1:0] StepRet   = 3'd7;

  typedef enum logic [2:0] {
    OpNop     = 3'd0,
    OpAccum   = 3'd1,
    OpDivLoad = 3'd2,
    OpDivStep = 3'd3,
    OpStore   = 3'd4,
    OpScale   = 3'd5,
    OpLed     = 3'd6,
    OpEmit    = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    CondNext     = 3'd0,
    CondGoto     = 3'd1,
    CondNoInput  = 3'd2,
    CondNoResult = 3'd3,
    CondDivMore  = 3'd4,
    CondOutBusy  = 3'd5
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PcW-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  // Control program: a true condition jumps to target, otherwise advance.
  function automatic uword_t ucode_rom(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{op: OpNop, cond: CondGoto, target: StepWait};
    case (pc)
      StepWait:  w = '{op: OpAccum,   cond: CondNoInput,  target: StepWait};
      StepCheck: w = '{op: OpDivLoad, cond: CondNoResult, target: StepWait};
      StepDiv:   w = '{op: OpDivStep, cond: CondDivMore,  target: StepDiv};
      StepStore: w = '{op: OpStore,   cond: CondNext,     target: StepWait};
      StepScale: w = '{op: OpScale,   cond: CondNext,     target: StepWait};
      StepLed:   w = '{op: OpLed,     cond: CondNext,     target: StepWait};
      StepEmit:  w = '{op: OpEmit,    cond: CondOutBusy,  target: StepEmit};
      StepRet:   w = '{op: OpNop,     cond: CondGoto,     target: StepWait};
      default:   w = '{op: OpNop,     cond: CondGoto,     target: StepWait};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/dsaled_div.sv -----
// Two-lane restoring divider: 32-bit sums by a 5-bit count, one quotient bit per step.
// Depends on dsaled_pkg.
module dsaled_div (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  dsaled_pkg::div_ctrl_t                                ctrl_i,
  input  logic [dsaled_pkg::CountW-1:0]                        divisor_i,
  input  logic [dsaled_pkg::NumLanes-1:0][dsaled_pkg::SumW-1:0] dividend_i,
  output logic [dsaled_pkg::NumLanes-1:0][dsaled_pkg::DataW-1:0] quotient_o,
  output logic                                                 last_o
);
  import dsaled_pkg::*;

  logic [DivCntW-1:0]                  cnt_q, cnt_d;
  logic [CountW-1:0]                   dvs_q;
  logic [NumLanes-1:0][CountW-1:0]     rem_q, rem_d;
  logic [NumLanes-1:0][DataW-1:0]      dq_q, dq_d;
  logic [NumLanes-1:0]                 sat_q, sat_d;

  always_comb begin
    logic [CountW:0] trial;
    logic            ge;
    trial = '0;
    ge    = 1'b0;
    cnt_d = cnt_q;
    rem_d = rem_q;
    dq_d  = dq_q;
    sat_d = sat_q;
    if (ctrl_i.load) begin
      cnt_d = DivCntW'(DivSteps);
      for (int l = 0; l < NumLanes; l++) begin
        // quotient overflows 16 bits when the upper half reaches the divisor
        sat_d[l] = (dividend_i[l][SumW-1:DataW] >= {11'd0, divisor_i});
        rem_d[l] = dividend_i[l][DataW+CountW-1:DataW];
        dq_d[l]  = dividend_i[l][DataW-1:0];
      end
    end else if (ctrl_i.step) begin
      cnt_d = cnt_q - 1'b1;
      for (int l = 0; l < NumLanes; l++) begin
        trial    = {rem_q[l], dq_q[l][DataW-1]};
        ge       = (trial >= {1'b0, dvs_q});
        rem_d[l] = ge ? CountW'(trial - {1'b0, dvs_q}) : trial[CountW-1:0];
        dq_d[l]  = {dq_q[l][DataW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      dvs_q <= divisor_i;
    end
    rem_q <= rem_d;
    dq_q  <= dq_d;
    sat_q <= sat_d;
  end

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      quotient_o[l] = sat_q[l] ? FullScale : dq_q[l];
    end
  end

  assign last_o = (cnt_q == DivCntW'(1));

endmodule

// ----- hw/rtl/dual_sensor_average_led_drive_top.sv -----
// Top level of the dual-sensor averaging block with LED compare drive.
// Depends on dsaled_pkg and dsaled_div.

// Each accepted item carries one light and one temperature sample. Samples are clamped to
// 0..65535 and added to 32-bit running sums for the channels that channel_mode enables.
// When the tick counter reaches sample_count (limited to MaxCount), both sums are divided
// by the count, the means and the three LED compare values are updated, and one result
// item is produced. Control is a microcode program of eight steps held in a constant table
// in the package; a step counter walks it and jumps on conditions. An item completing no
// average passes the accept and check steps; one that averages passes the divider, store,
// scale, LED, emit and return, plus any wait for the output register. The bit-serial
// restoring divider works both channels side by side, one quotient bit per cycle. A
// finished result sits in the output register, so the next item is taken while it waits.
// Configuration writes take effect at once and are meant only while the block is idle.
module dual_sensor_average_led_drive_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [dsaled_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [dsaled_pkg::CfgDataW-1:0]      cfg_data_i,
  // input items
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [dsaled_pkg::SampleW-1:0] light_sample_i,
  input  logic signed [dsaled_pkg::SampleW-1:0] temp_sample_i,
  // result items
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [dsaled_pkg::DataW-1:0]         light_mean_o,
  output logic [dsaled_pkg::DataW-1:0]         temp_mean_out_o,
  output logic [dsaled_pkg::DataW-1:0]         red_compare_o,
  output logic [dsaled_pkg::DataW-1:0]         green_compare_o,
  output logic [dsaled_pkg::DataW-1:0]         blue_compare_o
);
  import dsaled_pkg::*;

  // Clamp a signed reading to 0..65535.
  function automatic logic [DataW-1:0] clamp_sample(input logic [SampleW-1:0] raw);
    logic [DataW-1:0] v;
    if (raw[SampleW-1]) begin
      v = '0;
    end else if (|raw[SampleW-2:DataW]) begin
      v = FullScale;
    end else begin
      v = raw[DataW-1:0];
    end
    return v;
  endfunction

  // Configuration registers
  logic [1:0]        mode_q;
  logic              readout_q;
  logic [CountW-1:0] count_cfg_q;
  logic [2:0]        color_en_q;
  logic [DataW-1:0]  light_th_q;
  logic [DataW-1:0]  temp_th_q;

  // Accumulation and result state
  logic [SumW-1:0]  light_sum_q, temp_sum_q;
  logic [TickW-1:0] tick_q;
  logic [DataW-1:0] light_avg_q, temp_avg_q;
  logic [NumColors-1:0][DataW-1:0] led_q;
  logic [ProdW-1:0] prod_q;

  // Sequencer
  logic [PcW-1:0] pc_q, pc_d;
  uword_t         uw;

  // Output register
  logic             out_valid_q;
  logic [DataW-1:0] out_light_q, out_temp_q;
  logic [NumColors-1:0][DataW-1:0] out_led_q;

  logic              mode_wr;
  logic              accept;
  logic              no_result;
  logic              out_busy;
  logic              emit_fire;
  logic [CountW-1:0] count;
  logic              div_last;
  div_ctrl_t         div_ctrl;
  logic [NumLanes-1:0][SumW-1:0]  div_dividend;
  logic [NumLanes-1:0][DataW-1:0] div_quot;

  assign uw = ucode_rom(pc_q);

  // Limit the configured count to MaxCount.
  assign count = ({3'd0, count_cfg_q} > TickW'(MaxCount)) ? CountW'(MaxCount) : count_cfg_q;

  assign in_ready_o = (uw.op == OpAccum);
  assign accept     = in_valid_i && in_ready_o;
  assign no_result  = (count == '0) || (tick_q < {3'd0, count});
  assign out_busy   = out_valid_q && !out_ready_i;
  assign emit_fire  = (uw.op == OpEmit) && !out_busy;
  assign mode_wr    = cfg_we_i && (cfg_idx_i == CfgChannelMode) &&
                      (cfg_data_i[1:0] != mode_q);

  // Step counter: jump when the control word's condition holds, else advance.
  always_comb begin
    pc_d = pc_q + 1'b1;
    case (uw.cond)
      CondNext:     pc_d = pc_q + 1'b1;
      CondGoto:     pc_d = uw.target;
      CondNoInput:  pc_d = !in_valid_i ? uw.target : pc_q + 1'b1;
      CondNoResult: pc_d = no_result ? uw.target : pc_q + 1'b1;
      CondDivMore:  pc_d = !div_last ? uw.target : pc_q + 1'b1;
      CondOutBusy:  pc_d = out_busy ? uw.target : pc_q + 1'b1;
      default:      pc_d = pc_q + 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepWait;
    end else begin
      pc_q <= pc_d;
    end
  end

  // Configuration registers; an index beyond the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= RstChannelMode;
      readout_q   <= RstReadoutSelect;
      count_cfg_q <= RstSampleCount;
      color_en_q  <= RstColorEnable;
      light_th_q  <= RstLightThresh;
      temp_th_q   <= RstTempThresh;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgChannelMode:   mode_q      <= cfg_data_i[1:0];
        CfgReadoutSelect: readout_q   <= cfg_data_i[0];
        CfgSampleCount:   count_cfg_q <= cfg_data_i[CountW-1:0];
        CfgColorEnable:   color_en_q  <= cfg_data_i[2:0];
        CfgLightThresh:   light_th_q  <= cfg_data_i;
        CfgTempThresh:    temp_th_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Running sums and tick counter: clear on a mode change or once an average is taken,
  // add on each accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_sum_q <= '0;
      temp_sum_q  <= '0;
      tick_q      <= '0;
    end else if (mode_wr || (uw.op == OpLed)) begin
      light_sum_q <= '0;
      temp_sum_q  <= '0;
      tick_q      <= '0;
    end else if (accept) begin
      if (mode_q[0]) begin
        light_sum_q <= light_sum_q + {16'd0, clamp_sample(light_sample_i)};
      end
      if (mode_q[1]) begin
        temp_sum_q <= temp_sum_q + {16'd0, clamp_sample(temp_sample_i)};
      end
      if ((mode_q != ModeOff) && (tick_q != TickMax)) begin
        tick_q <= tick_q + 1'b1;
      end
    end
  end

  // Divider: load both sums at the check step, step through the loop.
  assign div_ctrl.load   = (uw.op == OpDivLoad);
  assign div_ctrl.step   = (uw.op == OpDivStep);
  assign div_dividend[0] = light_sum_q;
  assign div_dividend[1] = temp_sum_q;

  dsaled_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .divisor_i  (count),
    .dividend_i (div_dividend),
    .quotient_o (div_quot),
    .last_o     (div_last)
  );

  // Means: store only for the active channels; a mode change clears both.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_avg_q <= '0;
      temp_avg_q  <= '0;
    end else if (mode_wr) begin
      light_avg_q <= '0;
      temp_avg_q  <= '0;
    end else if (uw.op == OpStore) begin
      if (mode_q[0]) begin
        light_avg_q <= div_quot[0];
      end
      if (mode_q[1]) begin
        temp_avg_q <= div_quot[1];
      end
    end
  end

  // Temperature gain product, registered ahead of the offset and saturation.
  always_ff @(posedge clk_i) begin
    if (uw.op == OpScale) begin
      prod_q <= temp_avg_q * TempGain;
    end
  end

  // LED compares
  logic [ScaledW-1:0] scaled;
  logic [ScaledW-1:0] temp_diff;
  logic [DataW-1:0]   temp_drive;
  logic [DataW-1:0]   drive;
  logic               led_zero;
  logic               led_hold;

  always_comb begin
    scaled     = prod_q[ProdW-1:ScaleShift];
    temp_diff  = (scaled > TempOffset) ? (scaled - TempOffset) : '0;
    temp_drive = (|temp_diff[ScaledW-1:DataW]) ? FullScale : temp_diff[DataW-1:0];
    if (readout_q == ReadoutLight) begin
      led_zero = (light_avg_q < light_th_q);
      led_hold = 1'b0;
      drive    = ~light_avg_q;
    end else begin
      led_zero = (temp_avg_q < temp_th_q);
      led_hold = (temp_avg_q == temp_th_q);
      drive    = temp_drive;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q <= '0;
    end else if ((uw.op == OpLed) && !led_hold) begin
      for (int c = 0; c < NumColors; c++) begin
        if (led_zero) begin
          led_q[c] <= '0;
        end else begin
          led_q[c] <= color_en_q[c] ? drive : FullScale;
        end
      end
    end
  end

  // Output register: hold the result until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_light_q <= light_avg_q;
      out_temp_q  <= temp_avg_q;
      out_led_q   <= led_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign light_mean_o    = out_light_q;
  assign temp_mean_out_o = out_temp_q;
  assign red_compare_o   = out_led_q[0];
  assign green_compare_o = out_led_q[1];
  assign blue_compare_o  = out_led_q[2];

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for dual_sensor_average_led_drive_top: a directed stimulus table,
// then random configuration phases, checked against typed rows or the in-bench model.
// Depends on dsaled_pkg and the RTL of the block.
module testbench;
  import dsaled_pkg::*;

  // Indexes past the register list; writes to them must be ignored
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  localparam int RandomItems  = 1800;
  localparam int SettleCycles = 40;    // well past the average path
  localparam int IdleLimit    = 5000;  // cycles with no item moving on either side
  localparam int LongHold     = 500;   // receiver hold-off that backs up the block
  localparam int MaxGap       = 17;

  // One result item as it leaves the block
  typedef struct packed {
    logic [DataW-1:0] light_mean;
    logic [DataW-1:0] temp_level;
    logic [DataW-1:0] red;
    logic [DataW-1:0] green;
    logic [DataW-1:0] blue;
  } readout_t;

  typedef enum logic {RowWrite, RowTick} row_kind_e;

  // One row of the directed table: a register write or a sensor tick, with an optional
  // hand-computed result
  typedef struct packed {
    row_kind_e                 kind;
    logic [CfgIdxW-1:0]        idx;
    logic [CfgDataW-1:0]       data;
    logic signed [SampleW-1:0] light;
    logic signed [SampleW-1:0] temp;
    logic                      typed;
    readout_t                  want;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CfgIdxW-1:0]        cfg_idx;
  logic [CfgDataW-1:0]       cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [SampleW-1:0] light_in;
  logic signed [SampleW-1:0] temp_in;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [DataW-1:0]          light_mean;
  logic [DataW-1:0]          temp_out;
  logic [DataW-1:0]          red_cmp;
  logic [DataW-1:0]          green_cmp;
  logic [DataW-1:0]          blue_cmp;

  dual_sensor_average_led_drive_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .light_sample_i  (light_in),
    .temp_sample_i   (temp_in),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .light_mean_o    (light_mean),
    .temp_mean_out_o (temp_out),
    .red_compare_o   (red_cmp),
    .green_compare_o (green_cmp),
    .blue_compare_o  (blue_cmp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Averager model: register copies and running state
  // ---------------------------------------------------------------------------------------
  logic [1:0]        m_mode;
  logic              m_readout;
  logic [CountW-1:0] m_count;
  logic [2:0]        m_colors;
  logic [DataW-1:0]  m_light_thr;
  logic [DataW-1:0]  m_temp_thr;

  logic [SumW-1:0]   light_acc;
  logic [SumW-1:0]   temp_acc;
  logic [TickW-1:0]  ticks;
  logic [DataW-1:0]  light_avg;
  logic [DataW-1:0]  temp_avg;
  logic [DataW-1:0]  led_cmp [NumColors];

  readout_t  pending_readouts[$];   // results the block still owes, oldest first
  stim_row_t directed_rows[$];

  int  failures      = 0;
  int  results_seen  = 0;   // written by the output checker only
  int  results_taken = 0;   // receiver's copy of results_seen
  int  hold_token    = 0;   // bumped by the stimulus to request a long hold-off
  int  hold_seen     = 0;
  int  hold_left     = 0;
  int  rx_gap        = 0;
  bit  rx_quiet      = 1'b0;
  bit  tx_quiet      = 1'b0;
  int  idle_cycles   = 0;

  // Clamp a raw signed reading to the unsigned 16-bit sensor range
  function automatic logic [DataW-1:0] clamp_raw(logic signed [SampleW-1:0] raw);
    if (raw < 0) return '0;
    if (raw > 32'sd65535) return FullScale;
    return raw[DataW-1:0];
  endfunction

  // Integer mean, saturated: a lowered count can leave more samples in the sum
  function automatic logic [DataW-1:0] sat_mean(logic [SumW-1:0] sum, int unsigned n);
    logic [SumW-1:0] q;
    q = sum / n;
    return (q > 32'(FullScale)) ? FullScale : q[DataW-1:0];
  endfunction

  // Apply one register write to the model, masked to the register width
  task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (idx)
      CfgChannelMode: begin
        // only a change of mode drops the running average and the means
        if (data[1:0] != m_mode) begin
          m_mode    = data[1:0];
          light_acc = '0;
          temp_acc  = '0;
          ticks     = '0;
          light_avg = '0;
          temp_avg  = '0;
        end
      end
      CfgReadoutSelect: m_readout   = data[0];
      CfgSampleCount:   m_count     = data[CountW-1:0];
      CfgColorEnable:   m_colors    = data[2:0];
      CfgLightThresh:   m_light_thr = data[DataW-1:0];
      CfgTempThresh:    m_temp_thr  = data[DataW-1:0];
      default: ;
    endcase
  endtask

  // Advance the model by one sensor tick; flag and return a result when an average closes
  task automatic accumulate_tick(input logic signed [SampleW-1:0] l,
                                 input logic signed [SampleW-1:0] t,
                                 output logic emitted, output readout_t r);
    int unsigned     n;
    logic [SumW-1:0] scaled;
    logic [SumW-1:0] drive;
    emitted = 1'b0;
    r       = '0;
    n = (m_count > MaxCount) ? MaxCount : m_count;
    if (m_mode[0]) light_acc = light_acc + clamp_raw(l);
    if (m_mode[1]) temp_acc = temp_acc + clamp_raw(t);
    if (m_mode != ModeOff && ticks < TickMax) ticks = ticks + 1'b1;
    if (n != 0 && ticks >= n) begin
      if (m_mode[0]) light_avg = sat_mean(light_acc, n);
      if (m_mode[1]) temp_avg = sat_mean(temp_acc, n);
      if (m_readout == ReadoutLight) begin
        for (int c = 0; c < NumColors; c++) begin
          if (light_avg < m_light_thr) led_cmp[c] = '0;
          else led_cmp[c] = m_colors[c] ? FullScale - light_avg : FullScale;
        end
      end else if (temp_avg < m_temp_thr) begin
        for (int c = 0; c < NumColors; c++) led_cmp[c] = '0;
      end else if (temp_avg > m_temp_thr) begin
        // mean equal to the threshold falls through and keeps the old compares
        scaled = (32'(temp_avg) * 32'(TempGain)) >> ScaleShift;
        drive  = (scaled > 32'(TempOffset)) ? scaled - 32'(TempOffset) : '0;
        if (drive > 32'(FullScale)) drive = 32'(FullScale);
        for (int c = 0; c < NumColors; c++)
          led_cmp[c] = m_colors[c] ? drive[DataW-1:0] : FullScale;
      end
      light_acc = '0;
      temp_acc  = '0;
      ticks     = '0;
      emitted   = 1'b1;
      r = '{light_avg, temp_avg, led_cmp[0], led_cmp[1], led_cmp[2]};
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------------------

  // Write one register: enable is high for exactly one rising edge
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
    apply_reg(idx, data);
  endtask

  // Offer one sensor tick after a random gap and hold it until the block takes it. Valid
  // stays high after acceptance so that a back-to-back item needs no drop in between.
  task automatic offer_tick(input logic signed [SampleW-1:0] l,
                            input logic signed [SampleW-1:0] t,
                            output logic emitted, output readout_t r);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MaxGap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    light_in <= l;
    temp_in  <= t;
    do @(posedge clk); while (!in_ready);
    accumulate_tick(l, t, emitted, r);
  endtask

  // Drop valid, wait for every owed result, then let a tick with no result finish too
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Random reading: mostly in range, with negatives, overflows and full 32-bit noise
  function automatic logic signed [SampleW-1:0] draw_sample(logic [DataW-1:0] level,
                                                            bit steady);
    int unsigned pick;
    if (steady) return 32'(level);
    pick = $urandom_range(0, 15);
    case (pick)
      0:       return $urandom;
      1:       return $urandom | 32'h8000_0000;
      2:       return 32'sd65536 + $urandom_range(0, 1000);
      3:       return 32'(level);
      4:       return 32'sd65535;
      5:       return 32'sd0;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Receiver: one random gap per result, quiet stretches, and the long hold-off on request
  // ---------------------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LongHold;
    end
    if (results_seen != results_taken) begin
      results_taken = results_seen;
      if (results_taken % 40 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      rx_gap = rx_quiet ? 0 : $urandom_range(0, MaxGap);
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output checker: compare each accepted result with the oldest owed one
  // ---------------------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [DataW-1:0] want,
                             input logic [DataW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : check_out
    readout_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_readouts.size() == 0) begin
        $display("%0t: result with nothing owed: light %0d temp %0d rgb %0d %0d %0d",
                 $time, light_mean, temp_out, red_cmp, green_cmp, blue_cmp);
        failures++;
      end else begin
        want = pending_readouts.pop_front();
        check_field("light_mean", want.light_mean, light_mean);
        check_field("temp_mean_out", want.temp_level, temp_out);
        check_field("red_compare", want.red, red_cmp);
        check_field("green_compare", want.green, green_cmp);
        check_field("blue_compare", want.blue, blue_cmp);
      end
    end
  end

  // Watchdog: stop a run in which no item moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no item accepted for %0d cycles", $time, IdleLimit);
      $display("dual_sensor_average_led_drive_top verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    logic        emitted;
    readout_t    got_r;
    int          random_done;
    int          phase;
    int          n_items;
    int unsigned pick;
    bit          steady;
    logic [1:0]        mode_v;
    logic [CfgDataW-1:0] count_v;
    logic [DataW-1:0]  lthr_v;
    logic [DataW-1:0]  tthr_v;

    // Hold every input at a known value from time zero
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    light_in = '0;
    temp_in  = '0;

    // Model starts from the reset register values
    m_mode      = RstChannelMode;
    m_readout   = RstReadoutSelect;
    m_count     = RstSampleCount;
    m_colors    = RstColorEnable;
    m_light_thr = RstLightThresh;
    m_temp_thr  = RstTempThresh;
    light_acc   = '0;
    temp_acc    = '0;
    ticks       = '0;
    light_avg   = '0;
    temp_avg    = '0;
    for (int c = 0; c < NumColors; c++) led_cmp[c] = '0;

    // Directed table. Ticks with a typed result carry values worked out by hand; the rest
    // are checked against the model.
    directed_rows = '{
      // count 0 after reset: the tick accumulates, nothing comes out
      '{RowTick,  CfgChannelMode, 16'd0, 32'sd100, 32'sd200, 1'b0, '0},
      '{RowWrite, CfgChannelMode, 16'd3, 32'sd0, 32'sd0, 1'b0, '0},
      '{RowWrite, CfgSampleCount, 16'd1, 32'sd0, 32'sd0, 1'b0, '0},
      // most negative and most positive raw readings; temp drive saturates, colors off
      '{RowTick,  CfgChannelMode, 16'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1,
        '{16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd65535}},
      // temp below threshold clears the compares
      '{RowTick,  CfgChannelMode, 16'd0, -32'sd1, 32'sd0, 1'b1,
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
      '{RowWrite, CfgColorEnable, 16'd7, 32'sd0, 32'sd0, 1'b0, '0},
      // temp exactly at threshold keeps the old compares; light clamps high
      '{RowTick,  CfgChannelMode, 16'd0, 32'sd65536, 32'sd15000, 1'b1,
        '{16'd65535, 16'd15000, 16'd0, 16'd0, 16'd0}},
      '{RowWrite, CfgReadoutSelect, 16'd0, 32'sd0, 32'sd0, 1'b0, '0},
      '{RowTick,  CfgChannelMode, 16'd0, 32'sd65535, 32'sd0, 1'b1,
        '{16'd65535, 16'd0, 16'd0, 16'd0, 16'd0}},
      // light exactly at threshold drives, one below switches off
      '{RowTick,  CfgChannelMode, 16'd0, 32'sd13351, 32'sd0, 1'b1,
        '{16'd13351, 16'd0, 16'd52184, 16'd52184, 16'd52184}},
      '{RowTick,  CfgChannelMode, 16'd0, 32'sd13350, 32'sd5, 1'b1,
        '{16'd13350, 16'd5, 16'd0, 16'd0, 16'd0}},
      '{RowWrite, CfgColorEnable, 16'd5, 32'sd0, 32'sd0, 1'b0, '0},
      '{RowTick,  CfgChannelMode, 16'd0, 32'sd20000, 32'sd1, 1'b1,
        '{16'd20000, 16'd1, 16'd45535, 16'd65535, 16'd45535}},
      '{RowWrite, CfgReadoutSelect, 16'd1, 32'sd0, 32'sd0, 1'b0, '0},
      '{RowWrite, CfgTempThresh, 16'd0, 32'sd0, 32'sd0, 1'b0, '0},
      '{RowWrite, CfgLightThresh, 16'hFFFF, 32'sd0, 32'sd0, 1'b0, '0},
      // scaled temp under the offset floors at zero
      '{RowTick,  CfgChannelMode, 16'd0, 32'sd0, 32'sd1, 1'b1,
        '{16'd0, 16'd1, 16'd0, 16'd65535, 16'd0}},
      '{RowTick,  CfgChannelMode, 16'd0, 32'sd12345, 32'sd30000, 1'b0, '0},
      // temp-only mode: new mode clears both means, light mean stays at zero
      '{RowWrite, CfgChannelMode, 16'd2, 32'sd0, 32'sd0, 1'b0, '0},
      '{RowTick,  CfgChannelMode, 16'd0, 32'sd7, 32'sd20000, 1'b0, '0},
      // upper data bits are masked off: count becomes 5
      '{RowWrite, CfgSampleCount, 16'hFFE5, 32'sd0, 32'sd0, 1'b0, '0},
      '{RowTick,  CfgChannelMode, 16'd0, 32'sd0, 32'sd65535, 1'b0, '0},
      '{RowTick,  CfgChannelMode, 16'd0, 32'sd0, 32'sd65535, 1'b0, '0},
      '{RowTick,  CfgChannelMode, 16'd0, 32'sd0, 32'sd65535, 1'b0, '0},
      // count lowered under the ticks already taken: next tick closes, mean saturates
      '{RowWrite, CfgSampleCount, 16'd2, 32'sd0, 32'sd0, 1'b0, '0},
      '{RowTick,  CfgChannelMode, 16'd0, -32'sd5, 32'sd65535, 1'b0, '0},
      // writes past the register list and a rewrite of the same mode change nothing
      '{RowWrite, CfgSpareLo, 16'hFFFF, 32'sd0, 32'sd0, 1'b0, '0},
      '{RowWrite, CfgSpareHi, 16'hFFFF, 32'sd0, 32'sd0, 1'b0, '0},
      '{RowWrite, CfgChannelMode, 16'd2, 32'sd0, 32'sd0, 1'b0, '0},
      '{RowTick,  CfgChannelMode, 16'd0, 32'sd99, 32'sd40000, 1'b0, '0},
      // mode off: the tick is dropped entirely
      '{RowWrite, CfgChannelMode, 16'd0, 32'sd0, 32'sd0, 1'b0, '0},
      '{RowTick,  CfgChannelMode, 16'd0, 32'sd1000, 32'sd1000, 1'b0, '0},
      '{RowWrite, CfgChannelMode, 16'd1, 32'sd0, 32'sd0, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowWrite) begin
        settle_block();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        offer_tick(directed_rows[i].light, directed_rows[i].temp, emitted, got_r);
        if (directed_rows[i].typed) pending_readouts.push_back(directed_rows[i].want);
        else if (emitted) pending_readouts.push_back(got_r);
      end
    end

    // Random phases: settle, rewrite every register, then a run of ticks
    random_done = 0;
    phase = 0;
    while (random_done < RandomItems) begin
      settle_block();

      pick   = $urandom_range(0, 15);
      mode_v = (pick == 0) ? ModeOff : 2'($urandom_range(1, 3));
      pick   = $urandom_range(0, 19);
      case (pick)
        0:       count_v = 16'd0;
        1:       count_v = 16'(MaxCount);
        2:       count_v = 16'($urandom_range(25, 31));
        3:       count_v = 16'hFFE0 | 16'($urandom_range(0, 31));
        4:       count_v = 16'($urandom_range(7, 23));
        default: count_v = 16'($urandom_range(1, 6));
      endcase
      pick   = $urandom_range(0, 7);
      lthr_v = (pick == 0) ? '0 : (pick == 1) ? FullScale : 16'($urandom);
      pick   = $urandom_range(0, 7);
      tthr_v = (pick == 0) ? '0 : (pick == 1) ? FullScale : 16'($urandom);

      // one phase fills the block behind a long receiver hold-off
      if (phase == 2) begin
        mode_v  = 2'd3;
        count_v = 16'd1;
      end

      write_reg(CfgChannelMode, 16'(mode_v));
      write_reg(CfgReadoutSelect, 16'($urandom_range(0, 1)));
      write_reg(CfgSampleCount, count_v);
      write_reg(CfgColorEnable, 16'($urandom_range(0, 7)));
      write_reg(CfgLightThresh, lthr_v);
      write_reg(CfgTempThresh, tthr_v);
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi, 16'($urandom));

      tx_quiet = (phase == 2) || ($urandom_range(0, 3) == 0);
      steady   = ($urandom_range(0, 5) == 0);
      if (phase == 2) begin
        n_items = 60;
        hold_token++;
      end else if (m_mode == ModeOff || m_count == 0) begin
        n_items = 10;
      end else begin
        n_items = $urandom_range(8, 60);
      end

      for (int k = 0; k < n_items; k++) begin
        offer_tick(draw_sample(m_light_thr, steady), draw_sample(m_temp_thr, steady),
                   emitted, got_r);
        if (emitted) pending_readouts.push_back(got_r);
        if (m_mode != ModeOff) random_done++;
      end
      phase++;
    end

    // Drain, give the block time to show any stray result, then report
    settle_block();
    repeat (SettleCycles) @(posedge clk);
    if (pending_readouts.size() != 0)
      $display("%0t: %0d results never arrived", $time, pending_readouts.size());
    if (failures == 0 && pending_readouts.size() == 0) begin
      $display("dual_sensor_average_led_drive_top verification clean");
    end else begin
      $display("dual_sensor_average_led_drive_top verification failed");
    end
    $finish;
  end

endmodule

// ----- dual_sensor_average_led_drive_top.f -----
hw/rtl/dsaled_pkg.sv
hw/rtl/dsaled_div.sv
hw/rtl/dual_sensor_average_led_drive_top.sv
test/testbench.sv
